@@ hdl/sbfs_pkg.sv @@
// shared constants for the stern-brocot fraction search block
package sbfs_pkg;

    // configuration register widths and reset values
    localparam int unsigned TOL_W   = 20;
    localparam int unsigned STEPS_W = 25;
    localparam logic [TOL_W-1:0]   TOL_RESET       = TOL_W'(1);
    localparam logic [STEPS_W-1:0] MAX_STEPS_RESET = STEPS_W'(25'h100_0000);

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_STEPS = 1'b1;

    // result status codes
    localparam int unsigned STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_STEP_LIMIT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DEN_LIMIT = 2'd2;

endpackage

@@ hdl/stern_brocot_fraction_search.sv @@
// stern-brocot rational approximation of a signed fixed-point number
//
// Each transaction on the s_ side carries a sign, a whole part and a fraction scaled by
// 2^FRAC_BITS. The block walks the Stern-Brocot tree from the bounds 0/1 and 1/1, starting
// with 1/1 as the approximation, and stops when the approximation lies within tolerance
// (in units of 2^-FRAC_BITS), on an exact mediant, at max_steps mediant steps, or when the
// next mediant denominator would not fit in DEN_BITS. A 1/1 result carries into the whole
// part and a zero fraction gives 0/1. One m_ transaction is returned per input: sign, whole
// part, proper numerator and denominator, improper numerator and a status code. A zero
// fraction skips the walk; otherwise the walk takes one round per cycle through a single
// add/compare unit that keeps the bound errors and the tolerance products by addition
// only, then the states S_FIX, S_MUL and S_ADD carry, multiply and add up the improper
// numerator. The reset step limit is 2^24. s_tready is high only while the core is idle;
// a finished result sits in the output register, so the next item may be taken while it
// waits for m_tready. Configuration writes are taken in any cycle but are meant for idle
// periods only.
module stern_brocot_fraction_search #(
    parameter int unsigned FRAC_BITS  = 40,
    parameter int unsigned DEN_BITS   = 24,
    parameter int unsigned WHOLE_BITS = 32
) (
    input  logic aclk,
    input  logic aresetn,

    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [sbfs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sbfs_pkg::STEPS_W-1:0]         cfg_wdata,

    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // fields from bit 0: negative, whole_part, fraction_bits, zero padding
    input  logic [((1+WHOLE_BITS+FRAC_BITS+7)/8)*8-1:0] s_tdata,

    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // fields from bit 0: out_negative, out_whole, numerator, denominator,
    // improper_numerator, status, zero padding
    output logic [((1+(WHOLE_BITS+1)+2*DEN_BITS+(WHOLE_BITS+DEN_BITS)+2+7)/8)*8-1:0] m_tdata
);

    localparam int unsigned OUT_WHOLE_W = WHOLE_BITS + 1;
    localparam int unsigned IMP_W       = WHOLE_BITS + DEN_BITS;
    localparam int unsigned PROD_W      = OUT_WHOLE_W + DEN_BITS;
    localparam int unsigned OUT_FIELDS_W =
        1 + OUT_WHOLE_W + 2*DEN_BITS + IMP_W + sbfs_pkg::STATUS_W;
    localparam int unsigned OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
    // bound errors scaled by 2^FRAC_BITS never exceed 2^FRAC_BITS
    localparam int unsigned ERR_W  = FRAC_BITS + 1;
    localparam int unsigned DIFF_W = FRAC_BITS + 2;
    // tolerance times a denominator
    localparam int unsigned TOLD_W = sbfs_pkg::TOL_W + DEN_BITS;
    localparam int unsigned CMP_W  = (ERR_W > TOLD_W) ? ERR_W : TOLD_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RUN  = 5'b00010,
        S_FIX  = 5'b00100,
        S_MUL  = 5'b01000,
        S_ADD  = 5'b10000
    } state_t;

    // configuration registers
    logic [sbfs_pkg::TOL_W-1:0]   tolerance_reg;
    logic [sbfs_pkg::STEPS_W-1:0] max_steps_reg;

    // control
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // walk state
    logic                          sign_reg, sign_next;
    logic [OUT_WHOLE_W-1:0]        whole_reg, whole_next;
    logic [DEN_BITS-1:0]           ln_reg, ln_next, ld_reg, ld_next;
    logic [DEN_BITS-1:0]           rn_reg, rn_next, rd_reg, rd_next;
    logic [DEN_BITS-1:0]           n_reg, n_next, d_reg, d_next;
    logic [ERR_W-1:0]              el_reg, el_next, er_reg, er_next;
    logic [ERR_W-1:0]              cur_abs_reg, cur_abs_next;
    logic [TOLD_W-1:0]             tl_reg, tl_next, tr_reg, tr_next;
    logic [TOLD_W-1:0]             cur_tol_reg, cur_tol_next;
    logic [sbfs_pkg::STEPS_W-1:0]  step_reg, step_next, limit_reg, limit_next;
    logic [sbfs_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [IMP_W-1:0]              prod_reg, prod_next;

    // output register
    logic                          out_neg_reg, out_neg_next;
    logic [OUT_WHOLE_W-1:0]        out_whole_reg, out_whole_next;
    logic [DEN_BITS-1:0]           out_num_reg, out_num_next, out_den_reg, out_den_next;
    logic [IMP_W-1:0]              out_imp_reg, out_imp_next;
    logic [sbfs_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    // input unpacking
    logic                  in_negative;
    logic [WHOLE_BITS-1:0] in_whole;
    logic [FRAC_BITS-1:0]  in_frac;

    // shared add/compare unit
    logic [DEN_BITS:0]   md_wide;
    logic [DEN_BITS-1:0] mn;
    logic [DIFF_W-1:0]   diff;
    logic [ERR_W-1:0]    diff_abs;
    logic [TOLD_W-1:0]   tol_sum;
    logic                within_tol;
    logic [PROD_W-1:0]   prod_full;
    logic                s_accept;
    logic                out_free;

    assign in_negative = s_tdata[0];
    assign in_whole    = s_tdata[WHOLE_BITS:1];
    assign in_frac     = s_tdata[WHOLE_BITS+FRAC_BITS:WHOLE_BITS+1];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tdata = OUT_TDATA_W'({out_status_reg, out_imp_reg, out_den_reg, out_num_reg,
                                   out_whole_reg, out_neg_reg});

    // mediant of the bounds and its scaled error: f*md - mn*2^F = el - er
    assign md_wide    = {1'b0, ld_reg} + {1'b0, rd_reg};
    assign mn         = ln_reg + rn_reg;
    assign diff       = {1'b0, el_reg} - {1'b0, er_reg};
    assign diff_abs   = diff[DIFF_W-1] ? ERR_W'(-diff) : diff[ERR_W-1:0];
    assign tol_sum    = tl_reg + tr_reg;
    assign within_tol = CMP_W'(cur_abs_reg) <= CMP_W'(cur_tol_reg);

    assign prod_full = PROD_W'(whole_reg) * PROD_W'(d_reg);

    always_comb begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        sign_next       = sign_reg;
        whole_next      = whole_reg;
        ln_next         = ln_reg;
        ld_next         = ld_reg;
        rn_next         = rn_reg;
        rd_next         = rd_reg;
        n_next          = n_reg;
        d_next          = d_reg;
        el_next         = el_reg;
        er_next         = er_reg;
        cur_abs_next    = cur_abs_reg;
        tl_next         = tl_reg;
        tr_next         = tr_reg;
        cur_tol_next    = cur_tol_reg;
        step_next       = step_reg;
        limit_next      = limit_reg;
        status_next     = status_reg;
        prod_next       = prod_reg;
        out_neg_next    = out_neg_reg;
        out_whole_next  = out_whole_reg;
        out_num_next    = out_num_reg;
        out_den_next    = out_den_reg;
        out_imp_next    = out_imp_reg;
        out_status_next = out_status_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    sign_next    = in_negative;
                    whole_next   = OUT_WHOLE_W'(in_whole);
                    status_next  = sbfs_pkg::STATUS_OK;
                    ln_next      = '0;
                    ld_next      = DEN_BITS'(1);
                    rn_next      = DEN_BITS'(1);
                    rd_next      = DEN_BITS'(1);
                    // left bound 0/1 sits at error f, right bound 1/1 at 1 - f
                    el_next      = ERR_W'(in_frac);
                    er_next      = (ERR_W'(1) << FRAC_BITS) - ERR_W'(in_frac);
                    tl_next      = TOLD_W'(tolerance_reg);
                    tr_next      = TOLD_W'(tolerance_reg);
                    cur_abs_next = (ERR_W'(1) << FRAC_BITS) - ERR_W'(in_frac);
                    cur_tol_next = TOLD_W'(tolerance_reg);
                    step_next    = '0;
                    limit_next   = (max_steps_reg == '0) ? sbfs_pkg::STEPS_W'(1)
                                                         : max_steps_reg;
                    if (in_frac == '0) begin
                        n_next     = '0;
                        d_next     = DEN_BITS'(1);
                        state_next = S_FIX;
                    end else begin
                        n_next     = DEN_BITS'(1);
                        d_next     = DEN_BITS'(1);
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (within_tol) begin
                    status_next = sbfs_pkg::STATUS_OK;
                    state_next  = S_FIX;
                end else if (step_reg >= limit_reg) begin
                    status_next = sbfs_pkg::STATUS_STEP_LIMIT;
                    state_next  = S_FIX;
                end else if (md_wide[DEN_BITS]) begin
                    status_next = sbfs_pkg::STATUS_DEN_LIMIT;
                    state_next  = S_FIX;
                end else begin
                    step_next    = step_reg + sbfs_pkg::STEPS_W'(1);
                    n_next       = mn;
                    d_next       = md_wide[DEN_BITS-1:0];
                    cur_abs_next = diff_abs;
                    cur_tol_next = tol_sum;
                    if (diff == '0) begin
                        status_next = sbfs_pkg::STATUS_OK;
                        state_next  = S_FIX;
                    end else if (!diff[DIFF_W-1]) begin
                        // mediant below the fraction: it becomes the left bound
                        ln_next = mn;
                        ld_next = md_wide[DEN_BITS-1:0];
                        el_next = diff_abs;
                        tl_next = tol_sum;
                    end else begin
                        rn_next = mn;
                        rd_next = md_wide[DEN_BITS-1:0];
                        er_next = diff_abs;
                        tr_next = tol_sum;
                    end
                end
            end
            S_FIX: begin
                // a 1/1 result carries into the whole part
                if (n_reg == d_reg) begin
                    whole_next = whole_reg + OUT_WHOLE_W'(1);
                    n_next     = '0;
                    d_next     = DEN_BITS'(1);
                end
                state_next = S_MUL;
            end
            S_MUL: begin
                prod_next  = prod_full[IMP_W-1:0];
                state_next = S_ADD;
            end
            S_ADD: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_neg_next    = sign_reg;
                    out_whole_next  = whole_reg;
                    out_num_next    = n_reg;
                    out_den_next    = d_reg;
                    out_imp_next    = prod_reg + IMP_W'(n_reg);
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tolerance_reg <= sbfs_pkg::TOL_RESET;
            max_steps_reg <= sbfs_pkg::MAX_STEPS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sbfs_pkg::REG_TOLERANCE: tolerance_reg <= cfg_wdata[sbfs_pkg::TOL_W-1:0];
                sbfs_pkg::REG_MAX_STEPS: max_steps_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        sign_reg       <= sign_next;
        whole_reg      <= whole_next;
        ln_reg         <= ln_next;
        ld_reg         <= ld_next;
        rn_reg         <= rn_next;
        rd_reg         <= rd_next;
        n_reg          <= n_next;
        d_reg          <= d_next;
        el_reg         <= el_next;
        er_reg         <= er_next;
        cur_abs_reg    <= cur_abs_next;
        tl_reg         <= tl_next;
        tr_reg         <= tr_next;
        cur_tol_reg    <= cur_tol_next;
        step_reg       <= step_next;
        limit_reg      <= limit_next;
        status_reg     <= status_next;
        prod_reg       <= prod_next;
        out_neg_reg    <= out_neg_next;
        out_whole_reg  <= out_whole_next;
        out_num_reg    <= out_num_next;
        out_den_reg    <= out_den_next;
        out_imp_reg    <= out_imp_next;
        out_status_reg <= out_status_next;
    end

`ifndef SYNTH
    // core is busy right after taking an input transaction
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("core accepted a transaction but did not go busy");

    // a delivered fraction is proper with a non-zero denominator
    a_proper_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_den_reg != '0) && (out_num_reg < out_den_reg))
        else $error("result fraction is not proper");

    // step counter never runs past the limit while walking
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RUN |-> step_reg <= limit_reg)
        else $error("step counter beyond the step limit");

    // the approximation is always one of the two bounds, with its own error
    a_cur_is_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RUN |->
            (n_reg == ln_reg && d_reg == ld_reg && cur_abs_reg == el_reg) ||
            (n_reg == rn_reg && d_reg == rd_reg && cur_abs_reg == er_reg))
        else $error("approximation does not match a bound");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_status_reg == sbfs_pkg::STATUS_OK ||
                     out_status_reg == sbfs_pkg::STATUS_STEP_LIMIT ||
                     out_status_reg == sbfs_pkg::STATUS_DEN_LIMIT)
        else $error("undefined status code on the result");
`endif

endmodule

@@ dv/stern_brocot_fraction_search_tb.sv @@
// self-checking testbench for the stern-brocot fraction search block
module stern_brocot_fraction_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // block geometry, kept at the defaults of the block
    localparam int unsigned FRAC_W   = 40;
    localparam int unsigned DEN_W    = 24;
    localparam int unsigned WHOLE_W  = 32;
    localparam int unsigned S_DATA_W = ((1 + WHOLE_W + FRAC_W + 7) / 8) * 8;
    localparam int unsigned M_DATA_W =
        ((1 + (WHOLE_W + 1) + 2 * DEN_W + (WHOLE_W + DEN_W) + 2 + 7) / 8) * 8;

    localparam longint unsigned DEN_MAX = (64'd1 << DEN_W) - 1;
    localparam logic [FRAC_W-1:0] FRAC_ONES = '1;
    localparam logic [WHOLE_W-1:0] WHOLE_ONES = '1;
    // 2^40 / golden ratio: all partial quotients one, so the walk grows like fibonacci
    localparam logic [FRAC_W-1:0] GOLDEN_FRAC = 40'h9E_3779_B97F;
    localparam logic [FRAC_W-1:0] ONE_THIRD_FRAC = 40'h55_5555_5555;
    localparam logic [sbfs_pkg::TOL_W-1:0] TOL_MAX = '1;
    localparam logic [sbfs_pkg::STEPS_W-1:0] STEPS_MAX = '1;

    // an item holds the core through its walk and the steps after it; no walk here comes
    // near this limit, even with a stall on each side, so it leaves a wide margin
    localparam int unsigned WATCHDOG_LIMIT = 100000;
    localparam int unsigned SETTLE_CYCLES  = 10;

    // fields packed from bit 0 upwards: negative, whole, fraction
    typedef struct packed {
        logic [FRAC_W-1:0]  fraction;
        logic [WHOLE_W-1:0] whole;
        logic               negative;
    } number_t;

    // fields packed from bit 0 upwards: negative, whole, numerator, denominator,
    // improper numerator, status
    typedef struct packed {
        logic [sbfs_pkg::STATUS_W-1:0] status;
        logic [WHOLE_W+DEN_W-1:0]      improper;
        logic [DEN_W-1:0]              denominator;
        logic [DEN_W-1:0]              numerator;
        logic [WHOLE_W:0]              whole;
        logic                          negative;
    } approximation_t;

    logic                             aclk;
    logic                             aresetn   = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [sbfs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [sbfs_pkg::STEPS_W-1:0]     cfg_wdata = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    // fields from bit 0: negative, whole_part, fraction_bits, zero padding
    logic [S_DATA_W-1:0]              s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    // fields from bit 0: out_negative, out_whole, numerator, denominator,
    // improper_numerator, status, zero padding
    logic [M_DATA_W-1:0]              m_tdata;

    // our own copy of the configuration, tracking every register write
    logic [sbfs_pkg::TOL_W-1:0]   tol_setting   = sbfs_pkg::TOL_RESET;
    logic [sbfs_pkg::STEPS_W-1:0] steps_setting = sbfs_pkg::MAX_STEPS_RESET;

    approximation_t awaited_approximations[$];
    bit             idling_on      = 1'b1;
    int             mismatches     = 0;
    int             numbers_sent   = 0;
    int             results_seen   = 0;
    int             status_tally[4] = '{default: 0};
    int             stall_cycles   = 0;
    int unsigned    quiet_cycles   = 0;

    stern_brocot_fraction_search #(
        .FRAC_BITS  (FRAC_W),
        .DEN_BITS   (DEN_W),
        .WHOLE_BITS (WHOLE_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // |f*d - n*2^40| <= tolerance*d, all in exact wide integers
    function automatic bit near_enough(logic [FRAC_W-1:0] f, logic [DEN_W:0] n,
                                       logic [DEN_W:0] d);
        logic [127:0] scaled, target, gap;
        scaled = 128'(f) * 128'(d);
        target = 128'(n) << FRAC_W;
        gap    = (scaled >= target) ? scaled - target : target - scaled;
        return gap <= 128'(tol_setting) * 128'(d);
    endfunction

    // mediant walk between lower and upper bounds, one round per loop pass
    function automatic approximation_t approximate_fraction(number_t x);
        approximation_t r;
        logic [DEN_W:0]   lo_n, lo_d, hi_n, hi_d, n, d, mn, md;
        logic [sbfs_pkg::STEPS_W:0] steps, limit;
        logic [WHOLE_W:0] whole;
        logic [sbfs_pkg::STATUS_W-1:0] status;
        logic [127:0]     scaled, target;
        bit               done;
        lo_n   = 0;
        lo_d   = 1;
        hi_n   = 1;
        hi_d   = 1;
        steps  = 0;
        limit  = (steps_setting == '0) ? (sbfs_pkg::STEPS_W+1)'(1) : {1'b0, steps_setting};
        whole  = {1'b0, x.whole};
        status = sbfs_pkg::STATUS_OK;
        done   = 1'b0;
        if (x.fraction == 0) begin
            // zero fraction: 0/1 straight away, no rounds
            n = 0;
            d = 1;
        end else begin
            n = 1;
            d = 1;
            while (!done) begin
                if (near_enough(x.fraction, n, d)) begin
                    done = 1'b1;
                end else if (steps >= limit) begin
                    status = sbfs_pkg::STATUS_STEP_LIMIT;
                    done   = 1'b1;
                end else if (64'(lo_d) + 64'(hi_d) > DEN_MAX) begin
                    // next mediant would not fit: keep the current approximation
                    status = sbfs_pkg::STATUS_DEN_LIMIT;
                    done   = 1'b1;
                end else begin
                    md     = lo_d + hi_d;
                    mn     = lo_n + hi_n;
                    steps  = steps + (sbfs_pkg::STEPS_W+1)'(1);
                    n      = mn;
                    d      = md;
                    scaled = 128'(x.fraction) * 128'(md);
                    target = 128'(mn) << FRAC_W;
                    if (scaled == target) begin
                        done = 1'b1;
                    end else if (scaled > target) begin
                        lo_n = mn;
                        lo_d = md;
                    end else begin
                        hi_n = mn;
                        hi_d = md;
                    end
                end
            end
        end
        // a 1/1 result carries into the whole part
        if (n == d) begin
            whole = whole + (WHOLE_W+1)'(1);
            n     = 0;
            d     = 1;
        end
        r.negative    = x.negative;
        r.whole       = whole;
        r.numerator   = n[DEN_W-1:0];
        r.denominator = d[DEN_W-1:0];
        r.improper    = (WHOLE_W + DEN_W)'(64'(whole) * 64'(d) + 64'(n));
        r.status      = status;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [WHOLE_W-1:0] random_whole();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return WHOLE_ONES;
            default: return $urandom;
        endcase
    endfunction

    // mix of zero, tiny, close to one, short dyadic and fully random fractions
    function automatic logic [FRAC_W-1:0] random_fraction();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return FRAC_W'(r) >> $urandom_range(20, 39);
            2:       return FRAC_ONES - (FRAC_W'(r) >> $urandom_range(20, 39));
            3:       return FRAC_W'($urandom_range(1, 255)) << $urandom_range(0, 32);
            default: return FRAC_W'(r);
        endcase
    endfunction

    // fractions away from zero and one, or within tolerance of one (immediate carry);
    // close to a simple fraction the walk can still be long, so a step bound caps it
    function automatic logic [FRAC_W-1:0] wide_tolerance_fraction();
        if ($urandom_range(0, 5) == 0)
            return FRAC_ONES - FRAC_W'($urandom_range(0, 1048574));
        return {10'($urandom_range(1, 1022)), 30'($urandom)};
    endfunction

    // one input transaction, with an occasional idle burst in front of it
    task automatic send_number(input logic negative, input logic [WHOLE_W-1:0] whole,
                               input logic [FRAC_W-1:0] fraction);
        number_t        item;
        approximation_t predicted;
        item.negative = negative;
        item.whole    = whole;
        item.fraction = fraction;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(item);
        do @(posedge aclk); while (s_tready !== 1'b1);
        // accepted at this edge, so the configuration in force is ours
        predicted = approximate_fraction(item);
        awaited_approximations.push_back(predicted);
        status_tally[predicted.status]++;
        numbers_sent++;
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (awaited_approximations.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // both registers written back to back while the block is idle
    task automatic configure(input logic [sbfs_pkg::TOL_W-1:0] tolerance,
                             input logic [sbfs_pkg::STEPS_W-1:0] max_steps);
        wait_for_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= sbfs_pkg::REG_TOLERANCE;
        cfg_wdata <= sbfs_pkg::STEPS_W'(tolerance);
        @(posedge aclk);
        cfg_index <= sbfs_pkg::REG_MAX_STEPS;
        cfg_wdata <= max_steps;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        tol_setting   = tolerance;
        steps_setting = max_steps;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // zero fraction gives 0/1 with no rounds; sign passes through, also on zero
    task automatic test_zero_fraction_and_sign();
        send_number(1'b0, '0, '0);
        send_number(1'b1, '0, '0);
        send_number(1'b1, WHOLE_ONES, '0);
        send_number(1'b0, WHOLE_ONES, '0);
    endtask

    // exact mediants and the 1/1 carry, under the reset configuration
    task automatic test_exact_fractions();
        send_number(1'b0, 32'd5, FRAC_W'(1) << (FRAC_W - 1));
        send_number(1'b1, 32'd7, FRAC_W'(3) << (FRAC_W - 2));
        send_number(1'b0, '0, FRAC_W'(5) << (FRAC_W - 3));
        send_number(1'b0, 32'd1, ONE_THIRD_FRAC);
        // within tolerance of one at the start: carries, whole part overflows to bit 32
        send_number(1'b0, WHOLE_ONES, FRAC_ONES);
        send_number(1'b1, 32'd123, FRAC_ONES);
    endtask

    // step limit of one, zero (taken as one) and a longer run at zero tolerance
    task automatic test_step_limit();
        configure(sbfs_pkg::TOL_W'(1), sbfs_pkg::STEPS_W'(1));
        send_number(1'b0, 32'd3, FRAC_W'(1));
        send_number(1'b1, '0, FRAC_ONES - 1);
        configure(sbfs_pkg::TOL_W'(1), sbfs_pkg::STEPS_W'(0));
        send_number(1'b0, 32'd9, FRAC_W'(1));
        configure(sbfs_pkg::TOL_W'(0), sbfs_pkg::STEPS_W'(50));
        send_number(1'b0, 32'd2, FRAC_ONES);
        send_number(1'b1, '0, FRAC_W'(1));
    endtask

    // fibonacci-like walks run into the denominator limit in a few dozen rounds
    task automatic test_denominator_limit();
        configure(sbfs_pkg::TOL_W'(0), STEPS_MAX);
        send_number(1'b0, random_whole(), GOLDEN_FRAC);
        send_number(1'b1, random_whole(), FRAC_ONES - GOLDEN_FRAC);
    endtask

    task automatic test_random_reset_tolerance();
        configure(sbfs_pkg::TOL_RESET, sbfs_pkg::STEPS_W'(4096));
        repeat (25) send_number(1'($urandom), random_whole(), random_fraction());
    endtask

    // short step bounds make the step limit the common outcome
    task automatic test_random_step_bound();
        configure(sbfs_pkg::TOL_W'($urandom_range(0, 255)),
                  sbfs_pkg::STEPS_W'($urandom_range(1, 64)));
        repeat (25) send_number(1'($urandom), random_whole(), random_fraction());
    endtask

    task automatic test_random_wide_tolerance();
        configure(TOL_MAX, sbfs_pkg::STEPS_W'(8192));
        repeat (25) send_number(1'($urandom), random_whole(), wide_tolerance_fraction());
    endtask

    // last stretch runs back to back with no idling on either side
    task automatic test_random_unstalled();
        configure(sbfs_pkg::TOL_W'($urandom_range(0, 1048575)),
                  sbfs_pkg::STEPS_W'($urandom_range(1, 8192)));
        idling_on = 1'b0;
        repeat (25) send_number(1'($urandom), random_whole(), random_fraction());
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [63:0] expected,
                                        logic [63:0] actual);
        if (actual !== expected) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            mismatches++;
        end
    endfunction

    // compares each accepted result transaction, then drives m_tready for the next
    // edge; values read here are the ones that decided the handshake at this edge
    always @(posedge aclk) begin
        approximation_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = approximation_t'(m_tdata[$bits(approximation_t)-1:0]);
            results_seen++;
            if (awaited_approximations.size() == 0) begin
                $error("result transaction with no prediction pending");
                mismatches++;
            end else begin
                want = awaited_approximations.pop_front();
                check_field("out_negative", 64'(want.negative), 64'(got.negative));
                check_field("out_whole", 64'(want.whole), 64'(got.whole));
                check_field("numerator", 64'(want.numerator), 64'(got.numerator));
                check_field("denominator", 64'(want.denominator), 64'(got.denominator));
                check_field("improper_numerator", 64'(want.improper), 64'(got.improper));
                check_field("status", 64'(want.status), 64'(got.status));
            end
        end
        // backpressure in random bursts while idling is on
        if (stall_cycles != 0) begin
            stall_cycles <= stall_cycles - 1;
            m_tready     <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_cycles <= $urandom_range(0, 9);
            m_tready     <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog: counts edges at which neither side moves a transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no transaction for %0d cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_zero_fraction_and_sign();
        test_exact_fractions();
        test_step_limit();
        test_denominator_limit();
        test_random_reset_tolerance();
        test_random_step_bound();
        test_random_wide_tolerance();
        test_random_unstalled();

        wait_for_results();
        $display(
            "%0d numbers: %0d within tolerance, %0d step limit, %0d denominator limit",
            numbers_sent, status_tally[sbfs_pkg::STATUS_OK],
            status_tally[sbfs_pkg::STATUS_STEP_LIMIT],
            status_tally[sbfs_pkg::STATUS_DEN_LIMIT]);
        $display("%0d results compared over nine register settings, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0 && results_seen == numbers_sent) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
